>>> design/vvao_pkg.sv
package vvao_pkg;

    localparam int CoordWidth = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] AO_FULL  = 2'd0;
    localparam logic [1:0] AO_LIGHT = 2'd1;
    localparam logic [1:0] AO_MID   = 2'd2;
    localparam logic [1:0] AO_DARK  = 2'd3;

    typedef struct packed {
        logic                  command;
        logic [CoordWidth-1:0] cell_x;
        logic [CoordWidth-1:0] cell_y;
        logic [CoordWidth-1:0] cell_z;
        logic                  active_bit;
        logic                  corner_x;
        logic                  corner_y;
        logic                  corner_z;
    } req_t;

    typedef struct packed {
        logic [1:0] ao_level;
    } rsp_t;

    function automatic logic [1:0] ao_code(input logic a, input logic b, input logic d);
        logic [1:0] code;
        priority if (a && b)
            code = AO_DARK;
        else if (d && (a || b))
            code = AO_MID;
        else if (a || b || d)
            code = AO_LIGHT;
        else
            code = AO_FULL;
        return code;
    endfunction

endpackage

>>> design/vvao_req_if.sv
interface vvao_req_if;
    logic              valid;
    logic              ready;
    vvao_pkg::req_t    item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> design/vvao_rsp_if.sv
interface vvao_rsp_if;
    logic              valid;
    logic              ready;
    vvao_pkg::rsp_t    item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> design/vvao_occ_mem.sv
// Occupancy store: one row of SIDE z-bits per (x, y), bit write, two read ports.
module vvao_occ_mem #(
    parameter int SIDE = 16,
    parameter int ROWS = SIDE * SIDE,
    parameter int AW   = $clog2(ROWS),
    parameter int CW   = $clog2(SIDE)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_row,
    input  logic [CW-1:0]   wr_col,
    input  logic            wr_bit,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_row_a,
    input  logic [AW-1:0]   rd_row_b,
    output logic [SIDE-1:0] rd_data_a,
    output logic [SIDE-1:0] rd_data_b,
    output logic            busy
);

    logic [SIDE-1:0] mem [ROWS];
    logic [SIDE-1:0] rd_a_reg;
    logic [SIDE-1:0] rd_b_reg;
    logic [AW-1:0]   clr_row_reg;
    logic [AW-1:0]   clr_row_next;
    logic            clr_busy_reg;
    logic            clr_busy_next;

    // clearing pass, one row per cycle
    always_comb
    begin
        clr_row_next  = clr_row_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_row_next = clr_row_reg + AW'(1);
            if (clr_row_reg == AW'(ROWS - 1))
                clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_row_reg  <= clr_row_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_row_reg] <= '0;
        else if (wr_en)
            mem[wr_row][wr_col] <= wr_bit;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_row_a];
            rd_b_reg <= mem[rd_row_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;
    assign busy      = clr_busy_reg;

endmodule

>>> design/voxel_vertex_ambient_occlusion_unit.sv
// A query's beat is read in the read stage, then its level is registered at the output.
// One beat per cycle, write or query, unless clearing or stalled; a write gives no result.
// Rate set by the two-port occupancy memory: both neighbour rows are read in the same cycle.
// Reset: asynchronous, active low; then a clearing pass over all SIDE*SIDE rows
// with ready low before the first beat is taken.
module voxel_vertex_ambient_occlusion_unit #(
    parameter int SIDE = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    vvao_req_if.sink   req,
    vvao_rsp_if.source rsp
);

    localparam int ROWS = SIDE * SIDE;
    localparam int AW   = $clog2(ROWS);
    localparam int CW   = $clog2(SIDE);
    localparam int EW   = 8;

    logic            accept;
    logic            busy;
    logic            advance;
    logic [EW-1:0]   xe, ye, ze, xn, yn, zn;
    logic            in_chunk;
    logic            faces_out;
    logic            wr_en;
    logic            rd_en;
    logic [AW-1:0]   wr_row, rd_row_a, rd_row_b;
    logic [SIDE-1:0] rd_data_a, rd_data_b;
    logic            nb_a, nb_b, nb_d;
    logic [1:0]      level;

    logic            s1_valid_reg, s1_valid_next;
    logic            s1_zero_reg;
    logic [CW-1:0]   s1_za_reg, s1_zb_reg;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      level_reg;

    assign accept = req.valid && req.ready;

    assign xe = EW'(req.item.cell_x);
    assign ye = EW'(req.item.cell_y);
    assign ze = EW'(req.item.cell_z);

    assign in_chunk = (xe < EW'(SIDE)) && (ye < EW'(SIDE)) && (ze < EW'(SIDE));

    assign faces_out =
        (req.item.corner_x && (xe == '0)) || (!req.item.corner_x && (xe == EW'(SIDE - 1))) ||
        (req.item.corner_y && (ye == '0)) || (!req.item.corner_y && (ye == EW'(SIDE - 1))) ||
        (req.item.corner_z && (ze == '0)) || (!req.item.corner_z && (ze == EW'(SIDE - 1)));

    // high corner steps down, low corner steps up
    assign xn = req.item.corner_x ? xe - EW'(1) : xe + EW'(1);
    assign yn = req.item.corner_y ? ye - EW'(1) : ye + EW'(1);
    assign zn = req.item.corner_z ? ze - EW'(1) : ze + EW'(1);

    assign wr_row   = AW'(AW'(xe) * AW'(SIDE) + AW'(ye));
    assign rd_row_a = AW'(AW'(xe) * AW'(SIDE) + AW'(yn));
    assign rd_row_b = AW'(AW'(xn) * AW'(SIDE) + AW'(yn));

    assign wr_en = accept && (req.item.command == vvao_pkg::CMD_WRITE) && in_chunk;
    assign rd_en = accept && (req.item.command == vvao_pkg::CMD_QUERY);

    vvao_occ_mem #(
        .SIDE (SIDE),
        .ROWS (ROWS),
        .AW   (AW),
        .CW   (CW)
    ) u_occ_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_row    (wr_row),
        .wr_col    (CW'(ze)),
        .wr_bit    (req.item.active_bit),
        .rd_en     (rd_en),
        .rd_row_a  (rd_row_a),
        .rd_row_b  (rd_row_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .busy      (busy)
    );

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !busy && (!s1_valid_reg || advance);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_valid_reg && advance)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_zero_reg <= !in_chunk || faces_out;
            s1_za_reg   <= CW'(zn);
            s1_zb_reg   <= CW'(ze);
        end
    end

    // a: (x, yn, zn)  b: (xn, yn, z)  d: (xn, yn, zn)
    assign nb_a  = rd_data_a[s1_za_reg];
    assign nb_b  = rd_data_b[s1_zb_reg];
    assign nb_d  = rd_data_b[s1_za_reg];
    assign level = s1_zero_reg ? vvao_pkg::AO_FULL : vvao_pkg::ao_code(nb_a, nb_b, nb_d);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
            level_reg <= level;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.item.ao_level = level_reg;

    a_no_beat_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) busy |-> !req.ready
    ) else $error("beat taken during clearing pass");

    a_query_enters_read_stage: assert property (
        @(posedge clk) disable iff (!rst_n) rd_en |=> s1_valid_reg
    ) else $error("accepted query lost before read stage");

    a_read_stage_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_za_reg) && $stable(s1_zb_reg))
    ) else $error("stalled query changed in read stage");

    a_write_in_chunk_only: assert property (
        @(posedge clk) disable iff (!rst_n) wr_en |-> (in_chunk && !busy)
    ) else $error("write outside chunk or during clearing");

endmodule
